/* rtl/assert_macros.svh */
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Expression must never hold.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

/* rtl/bkx_pkg.sv */
// Shared constants, codes and types of the binary trie k-th max xor block.
`timescale 1ns / 1ps
`default_nettype none

package bkx_pkg;

   localparam int KEY_BITS = 32;
   localparam int MAX_KEYS = 1024;

   localparam int KEY_W    = 32;
   localparam int RANK_W   = 11;
   localparam int STATUS_W = 2;
   localparam int FUNC_W   = 1;

   // nodes besides the root; the highest index is always a leaf
   localparam int NODE_CAP = MAX_KEYS * KEY_BITS;
   localparam int NODE_W   = $clog2(NODE_CAP + 1);
   localparam int ADDR_W   = $clog2(NODE_CAP);
   localparam int ROW_W    = 2 * NODE_W;
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);
   localparam int LVL_W    = $clog2(KEY_BITS);

   localparam int REQ_DATA_W = ((KEY_W + RANK_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((KEY_W + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANK = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // access request from the walker to the trie store
   typedef struct packed {
      logic              row_rd;
      logic [ADDR_W-1:0] row_rd_addr;
      logic              row_wr;
      logic [ADDR_W-1:0] row_wr_addr;
      logic [ROW_W-1:0]  row_wr_data;
      logic              cnt_rd;
      logic [ADDR_W-1:0] cnt_rd_addr;
      logic              cnt_wr;
      logic [ADDR_W-1:0] cnt_wr_addr;
      logic [CNT_W-1:0]  cnt_wr_data;
   } mem_req_type;

endpackage

`default_nettype wire

/* rtl/bkx_store.sv */
// Trie storage: child link rows and per-node key counts, registered reads.
`timescale 1ns / 1ps
`default_nettype none

module bkx_store (
   input  wire logic                       clock,
   input  wire bkx_pkg::mem_req_type       mem_req,
   output logic [bkx_pkg::ROW_W-1:0]       row_q_ff,
   output logic [bkx_pkg::CNT_W-1:0]       cnt_q_ff
);

   // row n: child 0 in the low half, child 1 in the high half
   logic [bkx_pkg::ROW_W-1:0] row_mem [bkx_pkg::NODE_CAP];
   // count of node n sits at entry n-1
   logic [bkx_pkg::CNT_W-1:0] cnt_mem [bkx_pkg::NODE_CAP];

   always_ff @(posedge clock) begin
      if (mem_req.row_wr) begin
         row_mem[mem_req.row_wr_addr] <= mem_req.row_wr_data;
      end
      if (mem_req.row_rd) begin
         row_q_ff <= row_mem[mem_req.row_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.cnt_wr) begin
         cnt_mem[mem_req.cnt_wr_addr] <= mem_req.cnt_wr_data;
      end
      if (mem_req.cnt_rd) begin
         cnt_q_ff <= cnt_mem[mem_req.cnt_rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/binary_trie_kth_max_xor.sv */
// Top level: binary trie of keys answering k-th largest xor queries.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage
//  req channel: one transaction per operation. tuser[0] = func (0 insert, 1 query),
//    tdata = key_value (bits 31:0), rank (bits 42:32), zero padding up to 48 bits.
//  rsp channel: exactly one transaction per request, in request order.
//    tdata = xor_result (bits 31:0), tuser = status (0 ok, 1 rank too large, 2 full).
//  Each item walks the trie one key bit per level, MSB first, the key sitting in a
//    shift register. A level is a row read and a decide step, followed by a count
//    read when a child's count is needed. Rejected items (rank too large, store
//    full) go straight to the result without walking the trie.
//  One item is in work at a time; req_tready is high only while the walker idles.
//  The finished result sits in an output register, so the next request is taken
//    while it waits; a stalled rsp side holds only a second finished result.
//  Reset (synchronous, active high) empties the store at once: node and key counts
//    go to zero and rows are only trusted once allocated, so no clearing pass runs.
module binary_trie_kth_max_xor (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [31:0] key_value, [42:32] rank, [47:43] zero
   input  wire logic [bkx_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] func
   input  wire logic [bkx_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] xor_result
   output logic [bkx_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // [1:0] status
   output logic [bkx_pkg::STATUS_W-1:0]            rsp_tuser
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_ROW  = 5'b00010,
      S_LINK = 5'b00100,
      S_CNT  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [bkx_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic [bkx_pkg::KEY_BITS-1:0]     key_ff, key_in;      // shifts left, MSB is the live bit
   logic [bkx_pkg::CNT_W-1:0]        r_ff, r_in;          // remaining rank
   logic [bkx_pkg::NODE_W-1:0]       u_ff, u_in;          // current node
   logic                             gone_ff, gone_in;    // path left the trie on insert
   logic [bkx_pkg::LVL_W-1:0]        lvl_ff, lvl_in;
   logic [bkx_pkg::KEY_BITS-1:0]     acc_ff, acc_in;      // result bits shift in at the LSB
   logic [bkx_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [bkx_pkg::NODE_W-1:0]       link_ff, link_in;    // node whose count is read
   logic [bkx_pkg::NODE_W-1:0]       near_ff, near_in;    // same-bit child on query
   logic [bkx_pkg::NODE_W-1:0]       nodes_used_ff, nodes_used_in;
   logic [bkx_pkg::CNT_W-1:0]        keys_stored_ff, keys_stored_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bkx_pkg::KEY_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [bkx_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   bkx_pkg::mem_req_type             mem_req;
   logic [bkx_pkg::ROW_W-1:0]        row_q_ff;
   logic [bkx_pkg::CNT_W-1:0]        cnt_q_ff;

   logic                             accept;
   logic                             rsp_load;
   logic [bkx_pkg::KEY_W-1:0]        req_key;
   logic [bkx_pkg::RANK_W-1:0]       req_rank;
   logic [bkx_pkg::RANK_W-1:0]       rank_eff;
   logic                             bit_cur;
   logic                             last;
   logic                             row_ok;
   logic [bkx_pkg::ROW_W-1:0]        row_eff;
   logic [bkx_pkg::NODE_W-1:0]       child0, child1;
   logic [bkx_pkg::NODE_W-1:0]       link_same, link_far;
   logic [bkx_pkg::NODE_W-1:0]       new_node;
   logic [bkx_pkg::NODE_W-1:0]       link_dec;
   logic [bkx_pkg::ROW_W-1:0]        row_new;
   logic                             advance;

   bkx_store u_store (
      .clock    (clock),
      .mem_req  (mem_req),
      .row_q_ff (row_q_ff),
      .cnt_q_ff (cnt_q_ff)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_key    = req_tdata[bkx_pkg::KEY_W-1:0];
   assign req_rank   = req_tdata[bkx_pkg::KEY_W +: bkx_pkg::RANK_W];
   assign rank_eff   = (req_rank == '0) ? bkx_pkg::RANK_W'(1) : req_rank;

   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign bit_cur    = key_ff[bkx_pkg::KEY_BITS-1];
   assign last       = (lvl_ff == bkx_pkg::LVL_W'(bkx_pkg::KEY_BITS - 1));

   // root row is unwritten until the first insert; fresh nodes have empty rows
   assign row_ok     = !gone_ff && !((u_ff == '0) && (nodes_used_ff == '0));
   assign row_eff    = row_ok ? row_q_ff : '0;
   assign child0     = row_eff[bkx_pkg::NODE_W-1:0];
   assign child1     = row_eff[bkx_pkg::ROW_W-1:bkx_pkg::NODE_W];
   assign link_same  = bit_cur ? child1 : child0;
   assign link_far   = bit_cur ? child0 : child1;
   assign new_node   = nodes_used_ff + bkx_pkg::NODE_W'(1);
   assign link_dec   = link_ff - bkx_pkg::NODE_W'(1);
   assign row_new    = bit_cur ? {new_node, child0} : {child1, new_node};

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      r_in           = r_ff;
      u_in           = u_ff;
      gone_in        = gone_ff;
      lvl_in         = lvl_ff;
      acc_in         = acc_ff;
      status_in      = status_ff;
      link_in        = link_ff;
      near_in        = near_ff;
      nodes_used_in  = nodes_used_ff;
      keys_stored_in = keys_stored_ff;
      advance        = 1'b0;
      mem_req        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = req_tuser;
               key_in    = req_key[bkx_pkg::KEY_BITS-1:0];
               r_in      = bkx_pkg::CNT_W'(rank_eff);
               u_in      = '0;
               gone_in   = 1'b0;
               lvl_in    = '0;
               acc_in    = '0;
               status_in = bkx_pkg::ST_OK;
               state_in  = S_ROW;
               // node space cannot run out before the key limit is reached
               if (req_tuser == bkx_pkg::FUNC_INSERT) begin
                  if (keys_stored_ff == bkx_pkg::CNT_W'(bkx_pkg::MAX_KEYS)) begin
                     status_in = bkx_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end
               end else if (rank_eff > keys_stored_ff) begin
                  status_in = bkx_pkg::ST_RANK;
                  state_in  = S_DONE;
               end
            end
         end
         S_ROW: begin
            mem_req.row_rd      = !gone_ff;
            mem_req.row_rd_addr = u_ff[bkx_pkg::ADDR_W-1:0];
            state_in            = S_LINK;
         end
         S_LINK: begin
            if (func_ff == bkx_pkg::FUNC_INSERT) begin
               if (gone_ff || (link_same == '0)) begin
                  // allocate a child, its count starts at one
                  nodes_used_in       = new_node;
                  mem_req.row_wr      = 1'b1;
                  mem_req.row_wr_addr = u_ff[bkx_pkg::ADDR_W-1:0];
                  mem_req.row_wr_data = row_new;
                  mem_req.cnt_wr      = 1'b1;
                  mem_req.cnt_wr_addr = nodes_used_ff[bkx_pkg::ADDR_W-1:0];
                  mem_req.cnt_wr_data = bkx_pkg::CNT_W'(1);
                  u_in                = new_node;
                  gone_in             = 1'b1;
                  advance             = 1'b1;
               end else begin
                  link_in             = link_same;
                  mem_req.cnt_rd      = 1'b1;
                  mem_req.cnt_rd_addr = link_same[bkx_pkg::ADDR_W-1:0]
                                        - bkx_pkg::ADDR_W'(1);
                  state_in            = S_CNT;
               end
            end else begin
               near_in = link_same;
               link_in = link_far;
               if (link_far == '0) begin
                  u_in    = link_same;
                  acc_in  = {acc_ff[bkx_pkg::KEY_BITS-2:0], 1'b0};
                  advance = 1'b1;
               end else begin
                  mem_req.cnt_rd      = 1'b1;
                  mem_req.cnt_rd_addr = link_far[bkx_pkg::ADDR_W-1:0]
                                        - bkx_pkg::ADDR_W'(1);
                  state_in            = S_CNT;
               end
            end
         end
         S_CNT: begin
            if (func_ff == bkx_pkg::FUNC_INSERT) begin
               mem_req.cnt_wr      = 1'b1;
               mem_req.cnt_wr_addr = link_dec[bkx_pkg::ADDR_W-1:0];
               mem_req.cnt_wr_data = cnt_q_ff + bkx_pkg::CNT_W'(1);
               u_in                = link_ff;
            end else if (cnt_q_ff >= r_ff) begin
               u_in   = link_ff;
               acc_in = {acc_ff[bkx_pkg::KEY_BITS-2:0], 1'b1};
            end else begin
               r_in   = r_ff - cnt_q_ff;
               u_in   = near_ff;
               acc_in = {acc_ff[bkx_pkg::KEY_BITS-2:0], 1'b0};
            end
            advance = 1'b1;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         key_in = {key_ff[bkx_pkg::KEY_BITS-2:0], 1'b0};
         lvl_in = lvl_ff + bkx_pkg::LVL_W'(1);
         if (last) begin
            state_in = S_DONE;
            if (func_ff == bkx_pkg::FUNC_INSERT) begin
               keys_stored_in = keys_stored_ff + bkx_pkg::CNT_W'(1);
            end
         end else begin
            state_in = S_ROW;
         end
      end
   end

   // output register: acc stays zero for inserts and rejected items
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = bkx_pkg::KEY_W'(acc_ff);
         rsp_status_in = status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         nodes_used_ff  <= '0;
         keys_stored_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         nodes_used_ff  <= nodes_used_in;
         keys_stored_ff <= keys_stored_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      r_ff          <= r_in;
      u_ff          <= u_in;
      gone_ff       <= gone_in;
      lvl_ff        <= lvl_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      link_ff       <= link_in;
      near_ff       <= near_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bkx_pkg::RSP_DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_status_ff;

   `ASSERT_IMP(a_rsp_no_overwrite, clock, reset, rsp_load, (!rsp_valid_ff || rsp_tready), "result overwrote a pending transaction")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready, "request taken while walker busy")
   `ASSERT_NEVER(a_keys_bound, clock, reset, (keys_stored_ff > bkx_pkg::CNT_W'(bkx_pkg::MAX_KEYS)), "stored key count over limit")
   `ASSERT_IMP(a_rank_live, clock, reset, ((func_ff == bkx_pkg::FUNC_QUERY) && (status_ff == bkx_pkg::ST_OK) && (state_ff != S_IDLE) && (state_ff != S_DONE)), (r_ff != '0), "query rank dropped to zero")
   `ASSERT_IMP(a_nodes_bound, clock, reset, (state_ff == S_IDLE), (32'(nodes_used_ff) <= 32'(keys_stored_ff) * 32'(bkx_pkg::KEY_BITS)), "node count exceeds keys times depth")

endmodule

`default_nettype wire
